// ===== hdl/rssh_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes, constants and saturation helpers for the ray-sphere shader.
// No dependencies; imported by every module of the block but rssh_ram.
package rssh_pkg;

    localparam int ACC_W = 52;
    localparam int T_W   = 35;
    localparam int U_W   = 18;
    localparam int NDL_W = 18;
    localparam int COL_W = 32;

    localparam logic [15:0] BG_COLOR = 16'd8192;
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [5:0]  SQRT_STEPS = 6'd32;
    localparam logic [5:0]  DIV_STEPS  = 6'd48;

    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;
    localparam logic [1:0] CFG_COUNT    = 2'd3;

    localparam logic OPER_LOAD  = 1'b0;
    localparam logic OPER_TRACE = 1'b1;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        radius;
        logic [15:0]        surf_r;
        logic [15:0]        surf_g;
        logic [15:0]        surf_b;
        logic [15:0]        emit_r;
        logic [15:0]        emit_g;
        logic [15:0]        emit_b;
    } sphere_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_LOAD_L,
        OP_TCA,
        OP_R2,
        OP_SQRT_T,
        OP_SQRT_U,
        OP_UPD,
        OP_BEST,
        OP_TN,
        OP_PHIT,
        OP_NV,
        OP_DIV,
        OP_UNIT,
        OP_NHIT,
        OP_LIGHT,
        OP_SHSET,
        OP_NDL,
        OP_COL,
        OP_FIN
    } dp_op_t;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_L_RD,
        MS_L_L,
        MS_TCA,
        MS_R,
        MS_DIR_T,
        MS_V_V,
        MS_N_U,
        MS_SURF,
        MS_EMIT
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t msel;
        acc_op_t  acc;
        logic [1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic emit_zero;
        logic found;
        logic sq_busy;
        logic dv_busy;
    } dp_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_L,
        ST_T_DM,
        ST_T_DA,
        ST_T_TCA,
        ST_T_LM,
        ST_T_LA,
        ST_T_TM,
        ST_T_TA,
        ST_T_RM,
        ST_T_RA,
        ST_T_CMP,
        ST_P_SQ,
        ST_P_SW,
        ST_P_UPD,
        ST_P_NEXT,
        ST_B_RD,
        ST_B_LAT,
        ST_H_TN,
        ST_H_M,
        ST_H_A,
        ST_H_NV,
        ST_U_M,
        ST_U_A,
        ST_U_SQ,
        ST_U_SW,
        ST_U_DS,
        ST_U_DW,
        ST_U_ST,
        ST_H_N,
        ST_L_RD,
        ST_L_CHK,
        ST_L_SET,
        ST_S_PICK,
        ST_S_NEXT,
        ST_N_M,
        ST_N_A,
        ST_N_CL,
        ST_C_M1,
        ST_C_M2,
        ST_C_A,
        ST_L_NEXT,
        ST_FIN
    } ctrl_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647))
            r = 32'sh7FFFFFFF;
        else if (v < ACC_W'(-64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic [COL_W:0] v);
        logic [15:0] r;
        if (v > (COL_W+1)'(16'hFFFF))
            r = 16'hFFFF;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== hdl/rssh_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rssh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/rssh_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the ray-sphere shader: primary search, shading, shadow loops.
// Depends on rssh_pkg; drives rssh_dp through dp_cmd_t.
module rssh_ctrl
    import rssh_pkg::*;
#(
    parameter int MAX_SPHERES = 8,
    parameter int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1,
    parameter int CNT_W = $clog2(MAX_SPHERES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          operation,
    input  logic [3:0]    sphere_count,
    output logic          busy,
    output dp_cmd_t       cmd,
    output logic [AW-1:0] idx,
    output logic [AW-1:0] raddr,
    input  dp_stat_t      stat,
    input  logic [AW-1:0] best
);

    ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, n_cnt, i_inc, j_inc;
    logic [1:0] k_reg, k_next;
    logic shadow_reg, shadow_next, light_reg, light_next;
    logic [7:0] cnt8;

    assign cnt8  = 8'(sphere_count);
    assign n_cnt = (cnt8 > 8'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES) : CNT_W'(cnt8);
    assign i_inc = i_reg + CNT_W'(1);
    assign j_inc = j_reg + CNT_W'(1);
    assign busy  = (state_reg != ST_IDLE);
    assign idx   = i_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            shadow_reg <= 1'b0;
            light_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            shadow_reg <= shadow_next;
            light_reg  <= light_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        shadow_next = shadow_reg;
        light_next  = light_reg;
        cmd.op      = OP_NONE;
        cmd.msel    = MS_NONE;
        cmd.acc     = ACC_NONE;
        cmd.k       = k_reg;
        raddr       = i_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && operation == OPER_TRACE)
                begin
                    cmd.op      = OP_START;
                    i_next      = '0;
                    k_next      = '0;
                    shadow_next = 1'b0;
                    state_next  = (n_cnt == '0) ? ST_FIN : ST_T_RD;
                end
            end
            ST_T_RD:
            begin
                if (shadow_reg)
                    raddr = j_reg[AW-1:0];
                state_next = ST_T_L;
            end
            ST_T_L:
            begin
                cmd.op     = OP_LOAD_L;
                k_next     = '0;
                state_next = ST_T_DM;
            end
            ST_T_DM:
            begin
                cmd.msel   = MS_L_RD;
                state_next = ST_T_DA;
            end
            ST_T_DA:
            begin
                cmd.acc = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_T_TCA : ST_T_DM;
            end
            ST_T_TCA:
            begin
                cmd.op     = OP_TCA;
                k_next     = '0;
                state_next = ST_T_LM;
            end
            ST_T_LM:
            begin
                cmd.msel   = MS_L_L;
                state_next = ST_T_LA;
            end
            ST_T_LA:
            begin
                cmd.acc = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_T_TM : ST_T_LM;
            end
            ST_T_TM:
            begin
                cmd.msel   = MS_TCA;
                state_next = ST_T_TA;
            end
            ST_T_TA:
            begin
                cmd.acc    = ACC_SUB;
                state_next = ST_T_RM;
            end
            ST_T_RM:
            begin
                cmd.msel   = MS_R;
                state_next = ST_T_RA;
            end
            ST_T_RA:
            begin
                cmd.op     = OP_R2;
                state_next = ST_T_CMP;
            end
            ST_T_CMP:
            begin
                if (stat.reject)
                    state_next = shadow_reg ? ST_S_NEXT : ST_P_NEXT;
                else if (shadow_reg)
                    state_next = ST_L_NEXT;
                else
                    state_next = ST_P_SQ;
            end
            ST_P_SQ:
            begin
                cmd.op     = OP_SQRT_T;
                state_next = ST_P_SW;
            end
            ST_P_SW:
            begin
                if (!stat.sq_busy)
                    state_next = ST_P_UPD;
            end
            ST_P_UPD:
            begin
                cmd.op     = OP_UPD;
                state_next = ST_P_NEXT;
            end
            ST_P_NEXT:
            begin
                i_next = i_inc;
                if (i_inc < n_cnt)
                    state_next = ST_T_RD;
                else
                    state_next = stat.found ? ST_B_RD : ST_FIN;
            end
            ST_B_RD:
            begin
                raddr      = best;
                state_next = ST_B_LAT;
            end
            ST_B_LAT:
            begin
                cmd.op     = OP_BEST;
                state_next = ST_H_TN;
            end
            ST_H_TN:
            begin
                cmd.op     = OP_TN;
                k_next     = '0;
                state_next = ST_H_M;
            end
            ST_H_M:
            begin
                cmd.msel   = MS_DIR_T;
                state_next = ST_H_A;
            end
            ST_H_A:
            begin
                cmd.op  = OP_PHIT;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_H_NV : ST_H_M;
            end
            ST_H_NV:
            begin
                cmd.op     = OP_NV;
                light_next = 1'b0;
                k_next     = '0;
                state_next = ST_U_M;
            end
            ST_U_M:
            begin
                cmd.msel   = MS_V_V;
                state_next = ST_U_A;
            end
            ST_U_A:
            begin
                cmd.acc = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_U_SQ : ST_U_M;
            end
            ST_U_SQ:
            begin
                cmd.op     = OP_SQRT_U;
                k_next     = '0;
                state_next = ST_U_SW;
            end
            ST_U_SW:
            begin
                if (!stat.sq_busy)
                    state_next = ST_U_DS;
            end
            ST_U_DS:
            begin
                cmd.op     = OP_DIV;
                state_next = ST_U_DW;
            end
            ST_U_DW:
            begin
                if (!stat.dv_busy)
                    state_next = ST_U_ST;
            end
            ST_U_ST:
            begin
                cmd.op = OP_UNIT;
                k_next = k_reg + 2'd1;
                if (k_reg != 2'd2)
                    state_next = ST_U_DS;
                else
                    state_next = light_reg ? ST_L_SET : ST_H_N;
            end
            ST_H_N:
            begin
                cmd.op     = OP_NHIT;
                i_next     = '0;
                state_next = ST_L_RD;
            end
            ST_L_RD:
            begin
                state_next = ST_L_CHK;
            end
            ST_L_CHK:
            begin
                if (stat.emit_zero)
                    state_next = ST_L_NEXT;
                else
                begin
                    cmd.op     = OP_LIGHT;
                    light_next = 1'b1;
                    k_next     = '0;
                    state_next = ST_U_M;
                end
            end
            ST_L_SET:
            begin
                cmd.op      = OP_SHSET;
                shadow_next = 1'b1;
                j_next      = '0;
                state_next  = ST_S_PICK;
            end
            ST_S_PICK:
            begin
                if (j_reg >= n_cnt)
                begin
                    shadow_next = 1'b0;
                    k_next      = '0;
                    state_next  = ST_N_M;
                end
                else if (j_reg == i_reg)
                    j_next = j_inc;
                else
                    state_next = ST_T_RD;
            end
            ST_S_NEXT:
            begin
                j_next     = j_inc;
                state_next = ST_S_PICK;
            end
            ST_N_M:
            begin
                cmd.msel   = MS_N_U;
                state_next = ST_N_A;
            end
            ST_N_A:
            begin
                cmd.acc = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_N_CL : ST_N_M;
            end
            ST_N_CL:
            begin
                cmd.op     = OP_NDL;
                k_next     = '0;
                state_next = ST_C_M1;
            end
            ST_C_M1:
            begin
                cmd.msel   = MS_SURF;
                state_next = ST_C_M2;
            end
            ST_C_M2:
            begin
                cmd.msel   = MS_EMIT;
                state_next = ST_C_A;
            end
            ST_C_A:
            begin
                cmd.op  = OP_COL;
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_L_NEXT : ST_C_M1;
            end
            ST_L_NEXT:
            begin
                shadow_next = 1'b0;
                i_next      = i_inc;
                state_next  = (i_inc < n_cnt) ? ST_L_RD : ST_FIN;
            end
            ST_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rssh_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the ray-sphere shader: shared multiplier, accumulator,
// bit-serial square root and divider, vector and colour registers. Uses rssh_pkg.
module rssh_dp
    import rssh_pkg::*;
#(
    parameter int MAX_SPHERES = 8,
    parameter int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [AW-1:0]      idx,
    input  logic signed [31:0] org_x,
    input  logic signed [31:0] org_y,
    input  logic signed [31:0] org_z,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  sphere_t            ram_q,
    output dp_stat_t           stat,
    output logic [AW-1:0]      best,
    output logic [15:0]        color_r,
    output logic [15:0]        color_g,
    output logic [15:0]        color_b,
    output logic               hit,
    output logic               result_valid
);

    logic signed [31:0] ro [3];
    logic signed [31:0] rd [3];
    logic signed [31:0] l [3];
    logic signed [31:0] v [3];
    logic signed [31:0] phit [3];
    logic signed [31:0] sorg [3];
    logic signed [31:0] bc [3];
    logic signed [U_W-1:0] u [3];
    logic signed [U_W-1:0] nhit [3];
    logic [15:0] bsurf [3];
    logic [15:0] bemit [3];
    logic [15:0] lemit [3];
    logic [COL_W-1:0] col [3];
    logic signed [31:0] rc [3];

    logic [30:0] r_reg;
    logic signed [31:0] tca_reg, tn_reg;
    logic [46:0] r2_reg;
    logic signed [ACC_W-1:0] acc_reg, fl;
    logic signed [63:0] m_reg, prod;
    logic signed [31:0] ma, mb;
    logic signed [T_W-1:0] tnear_reg, t0, t1, tsel;
    logic [NDL_W-1:0] ndl_reg;
    logic found_reg;
    logic [AW-1:0] best_reg;
    logic valid_reg;
    logic signed [ACC_W-1:0] r2_s, rdiff;

    logic [63:0] sq_rad;
    logic [33:0] sq_rem;
    logic [31:0] sq_root;
    logic [5:0]  sq_cnt;
    logic [35:0] sq_sh;
    logic [33:0] sq_trial;

    logic [47:0] dv_num;
    logic [31:0] dv_rem;
    logic [47:0] dv_q;
    logic [5:0]  dv_cnt;
    logic        dv_neg;
    logic [32:0] dv_sh;
    logic [31:0] absv;
    logic [16:0] umag;

    assign rc[0] = ram_q.cx;
    assign rc[1] = ram_q.cy;
    assign rc[2] = ram_q.cz;

    assign fl   = ACC_W'(m_reg >>> 16);
    assign prod = ma * mb;
    assign r2_s = $signed({{(ACC_W-47){1'b0}}, r2_reg});
    assign rdiff = r2_s - acc_reg;

    assign t0   = T_W'(tca_reg) - $signed({3'b000, sq_root});
    assign t1   = T_W'(tca_reg) + $signed({3'b000, sq_root});
    assign tsel = t0[T_W-1] ? t1 : t0;

    assign sq_sh    = {sq_rem, sq_rad[63:62]};
    assign sq_trial = {sq_root, 2'b01};
    assign dv_sh    = {dv_rem, dv_num[47]};
    assign absv     = v[cmd.k][31] ? 32'(~v[cmd.k] + 32'sd1) : 32'(v[cmd.k]);
    assign umag     = (sq_root == '0) ? '0 :
                      ((dv_q > 48'(ONE_Q16)) ? ONE_Q16 : dv_q[16:0]);

    assign stat.reject    = tca_reg[31] || (acc_reg > r2_s);
    assign stat.emit_zero = (ram_q.emit_r == '0);
    assign stat.found     = found_reg;
    assign stat.sq_busy   = (sq_cnt != '0);
    assign stat.dv_busy   = (dv_cnt != '0);
    assign best           = best_reg;
    assign result_valid   = valid_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.msel)
            MS_L_RD:
            begin
                ma = l[cmd.k];
                mb = rd[cmd.k];
            end
            MS_L_L:
            begin
                ma = l[cmd.k];
                mb = l[cmd.k];
            end
            MS_TCA:
            begin
                ma = tca_reg;
                mb = tca_reg;
            end
            MS_R:
            begin
                ma = $signed({1'b0, r_reg});
                mb = $signed({1'b0, r_reg});
            end
            MS_DIR_T:
            begin
                ma = rd[cmd.k];
                mb = tn_reg;
            end
            MS_V_V:
            begin
                ma = v[cmd.k];
                mb = v[cmd.k];
            end
            MS_N_U:
            begin
                ma = 32'(nhit[cmd.k]);
                mb = 32'(u[cmd.k]);
            end
            MS_SURF:
            begin
                ma = $signed({16'd0, bsurf[cmd.k]});
                mb = $signed({{(32-NDL_W){1'b0}}, ndl_reg});
            end
            MS_EMIT:
            begin
                ma = $signed({1'b0, m_reg[46:16]});
                mb = $signed({16'd0, lemit[cmd.k]});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            valid_reg <= 1'b0;
            sq_cnt    <= '0;
            dv_cnt    <= '0;
        end
        else
        begin
            valid_reg <= (cmd.op == OP_FIN);
            if (cmd.op == OP_START)
                found_reg <= 1'b0;
            else if (cmd.op == OP_UPD && (!found_reg || tsel < tnear_reg))
                found_reg <= 1'b1;
            if (cmd.op == OP_SQRT_T || cmd.op == OP_SQRT_U)
                sq_cnt <= SQRT_STEPS;
            else if (sq_cnt != '0)
                sq_cnt <= sq_cnt - 6'd1;
            if (cmd.op == OP_DIV)
                dv_cnt <= DIV_STEPS;
            else if (dv_cnt != '0)
                dv_cnt <= dv_cnt - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.msel != MS_NONE)
            m_reg <= prod;

        case (cmd.acc)
            ACC_LOAD: acc_reg <= fl;
            ACC_ADD:  acc_reg <= acc_reg + fl;
            ACC_SUB:  acc_reg <= acc_reg - fl;
            default:  acc_reg <= acc_reg;
        endcase

        if (cmd.op == OP_SQRT_T || cmd.op == OP_SQRT_U)
        begin
            sq_rad  <= (cmd.op == OP_SQRT_T) ? {rdiff[47:0], 16'd0} : {acc_reg[47:0], 16'd0};
            sq_rem  <= '0;
            sq_root <= '0;
        end
        else if (sq_cnt != '0)
        begin
            sq_rad <= {sq_rad[61:0], 2'b00};
            if (sq_sh >= 36'(sq_trial))
            begin
                sq_rem  <= 34'(sq_sh - 36'(sq_trial));
                sq_root <= {sq_root[30:0], 1'b1};
            end
            else
            begin
                sq_rem  <= sq_sh[33:0];
                sq_root <= {sq_root[30:0], 1'b0};
            end
        end

        if (cmd.op == OP_DIV)
        begin
            dv_num <= {absv, 16'd0};
            dv_rem <= '0;
            dv_q   <= '0;
            dv_neg <= v[cmd.k][31];
        end
        else if (dv_cnt != '0)
        begin
            dv_num <= {dv_num[46:0], 1'b0};
            if (dv_sh >= {1'b0, sq_root})
            begin
                dv_rem <= 32'(dv_sh - {1'b0, sq_root});
                dv_q   <= {dv_q[46:0], 1'b1};
            end
            else
            begin
                dv_rem <= dv_sh[31:0];
                dv_q   <= {dv_q[46:0], 1'b0};
            end
        end

        case (cmd.op)
            OP_START:
            begin
                ro[0] <= org_x;
                ro[1] <= org_y;
                ro[2] <= org_z;
                rd[0] <= vec_x;
                rd[1] <= vec_y;
                rd[2] <= vec_z;
                for (int k = 0; k < 3; k++)
                    col[k] <= '0;
            end
            OP_LOAD_L:
            begin
                for (int k = 0; k < 3; k++)
                    l[k] <= sat32(ACC_W'(rc[k]) - ACC_W'(ro[k]));
                r_reg <= ram_q.radius;
            end
            OP_TCA:
                tca_reg <= sat32(acc_reg);
            OP_R2:
                r2_reg <= m_reg[62:16];
            OP_UPD:
            begin
                if (!found_reg || tsel < tnear_reg)
                begin
                    tnear_reg <= tsel;
                    best_reg  <= idx;
                end
            end
            OP_BEST:
            begin
                for (int k = 0; k < 3; k++)
                    bc[k] <= rc[k];
                bsurf[0] <= ram_q.surf_r;
                bsurf[1] <= ram_q.surf_g;
                bsurf[2] <= ram_q.surf_b;
                bemit[0] <= ram_q.emit_r;
                bemit[1] <= ram_q.emit_g;
                bemit[2] <= ram_q.emit_b;
            end
            OP_TN:
                tn_reg <= sat32(ACC_W'(tnear_reg));
            OP_PHIT:
                phit[cmd.k] <= sat32(ACC_W'(ro[cmd.k]) + fl);
            OP_NV:
            begin
                for (int k = 0; k < 3; k++)
                    v[k] <= sat32(ACC_W'(phit[k]) - ACC_W'(bc[k]));
            end
            OP_UNIT:
                u[cmd.k] <= dv_neg ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
            OP_NHIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nhit[k] <= u[k];
                    sorg[k] <= sat32(ACC_W'(phit[k]) + ACC_W'(u[k]));
                end
            end
            OP_LIGHT:
            begin
                for (int k = 0; k < 3; k++)
                    v[k] <= sat32(ACC_W'(rc[k]) - ACC_W'(phit[k]));
                lemit[0] <= ram_q.emit_r;
                lemit[1] <= ram_q.emit_g;
                lemit[2] <= ram_q.emit_b;
            end
            OP_SHSET:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ro[k] <= sorg[k];
                    rd[k] <= 32'(u[k]);
                end
            end
            OP_NDL:
                ndl_reg <= acc_reg[ACC_W-1] ? '0 : acc_reg[NDL_W-1:0];
            OP_COL:
                col[cmd.k] <= col[cmd.k] + m_reg[43:12];
            OP_FIN:
            begin
                hit <= found_reg;
                if (found_reg)
                begin
                    color_r <= sat16({1'b0, col[0]} + (COL_W+1)'(bemit[0]));
                    color_g <= sat16({1'b0, col[1]} + (COL_W+1)'(bemit[1]));
                    color_b <= sat16({1'b0, col[2]} + (COL_W+1)'(bemit[2]));
                end
                else
                begin
                    color_r <= BG_COLOR;
                    color_g <= BG_COLOR;
                    color_b <= BG_COLOR;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/ray_sphere_nearest_hit_shader_top.sv =====
`timescale 1ns / 1ps
// Top level of the ray-sphere shader: configuration registers, sphere RAM,
// sequencer and datapath. Depends on rssh_pkg, rssh_ram, rssh_ctrl, rssh_dp.
//
//   channel   signals                                   transfer when
//   -------   ---------------------------------------   ------------------------
//   command   start, busy, operation, entry_index,      start && !busy
//             vec_x/y/z, radius, surface_*, emit_*
//   result    result_valid, color_r/g/b, hit            result_valid (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// A load leaves busy low. A trace holds busy through a primary test of each of
// the n spheres in use, with a 32-step square root for each sphere hit; a hit
// then adds the hit point and normal (a 32-step square root and a 48-step
// division per axis), a check per sphere for emission, and per light the light
// vector normalization and the shadow tests.
// result_valid rises at the edge at which busy falls. Reset clears the
// configuration and control; sphere entries hold garbage until loaded.
// Results cannot be stalled.
module ray_sphere_nearest_hit_shader_top
    import rssh_pkg::*;
#(
    parameter int MAX_SPHERES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [2:0]         entry_index,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic [30:0]        radius,
    input  logic [15:0]        surface_r,
    input  logic [15:0]        surface_g,
    input  logic [15:0]        surface_b,
    input  logic [15:0]        emit_r,
    input  logic [15:0]        emit_g,
    input  logic [15:0]        emit_b,
    output logic               result_valid,
    output logic [15:0]        color_r,
    output logic [15:0]        color_g,
    output logic [15:0]        color_b,
    output logic               hit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [3:0] count_reg;
    logic [6:0] idx_wide;
    logic we;
    logic [AW-1:0] raddr, idx, best;
    sphere_t wentry, ram_q;
    dp_cmd_t cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;
    assign idx_wide  = 7'(entry_index);
    assign we        = start && !busy && (operation == OPER_LOAD) &&
                       (idx_wide < 7'(MAX_SPHERES));

    assign wentry.cx     = vec_x;
    assign wentry.cy     = vec_y;
    assign wentry.cz     = vec_z;
    assign wentry.radius = radius;
    assign wentry.surf_r = surface_r;
    assign wentry.surf_g = surface_g;
    assign wentry.surf_b = surface_b;
    assign wentry.emit_r = emit_r;
    assign wentry.emit_g = emit_g;
    assign wentry.emit_b = emit_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_data;
                CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                CFG_COUNT:    count_reg <= cfg_data[3:0];
                default:      count_reg <= count_reg;
            endcase
        end
    end

    rssh_ram #(
        .WIDTH ($bits(sphere_t)),
        .DEPTH (MAX_SPHERES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_wide[AW-1:0]),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (ram_q)
    );

    rssh_ctrl #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .sphere_count (count_reg),
        .busy         (busy),
        .cmd          (cmd),
        .idx          (idx),
        .raddr        (raddr),
        .stat         (stat),
        .best         (best)
    );

    rssh_dp #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .org_x        (org_x_reg),
        .org_y        (org_y_reg),
        .org_z        (org_z_reg),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .ram_q        (ram_q),
        .stat         (stat),
        .best         (best),
        .color_r      (color_r),
        .color_g      (color_g),
        .color_b      (color_b),
        .hit          (hit),
        .result_valid (result_valid)
    );

endmodule

// ===== verif/ray_sphere_nearest_hit_shader_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_sphere_nearest_hit_shader_top: loads sphere scenes,
// traces rays and compares each shaded result with an in-bench fixed-point shader.
// Depends on rssh_pkg and the RTL of the block.
module ray_sphere_nearest_hit_shader_top_tb;
    import rssh_pkg::*;

    localparam int NSPH = 8;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef longint vec3_t[3];
    typedef struct {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        hit;
    } shade_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic operation = OPER_LOAD;
    logic [2:0] entry_index = '0;
    logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic [30:0] radius = '0;
    logic [15:0] surface_r = '0, surface_g = '0, surface_b = '0;
    logic [15:0] emit_r = '0, emit_g = '0, emit_b = '0;
    logic result_valid;
    logic [15:0] color_r, color_g, color_b;
    logic hit;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_ORIGIN_X;
    logic [31:0] cfg_data = '0;

    // scene copy
    longint org_m[3];
    longint count_m;
    longint cen_m[NSPH][3];
    longint rad_m[NSPH];
    longint surf_m[NSPH][3];
    longint emit_m[NSPH][3];

    shade_t shade_q[$];
    int errors = 0;
    int n_loads = 0, n_traces = 0, n_hits = 0, n_cfg = 0;
    int idle_pct = 0;
    longint cycles = 0;

    ray_sphere_nearest_hit_shader_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        shade_t e;
        if (rst_n && result_valid)
        begin
            if (shade_q.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                e = shade_q.pop_front();
                if (e.hit)
                    n_hits++;
                if (color_r !== e.r)
                begin
                    $error("color_r expected %0d actual %0d", e.r, color_r);
                    errors++;
                end
                if (color_g !== e.g)
                begin
                    $error("color_g expected %0d actual %0d", e.g, color_g);
                    errors++;
                end
                if (color_b !== e.b)
                begin
                    $error("color_b expected %0d actual %0d", e.b, color_b);
                    errors++;
                end
                if (hit !== e.hit)
                begin
                    $error("hit expected %0d actual %0d", e.hit, hit);
                    errors++;
                end
            end
        end
    end

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint dot_q16(vec3_t a, vec3_t b);
        return ((a[0] * b[0]) >>> 16) + ((a[1] * b[1]) >>> 16) + ((a[2] * b[2]) >>> 16);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic vec3_t normalize_q16(vec3_t v);
        vec3_t o;
        longint unsigned len2, len;
        longint c;
        len2 = longint'(dot_q16(v, v));
        len = root_floor(len2 << 16);
        for (int k = 0; k < 3; k++)
        begin
            c = 0;
            if (len != 0)
            begin
                c = (v[k] * 65536) / longint'(len);
                if (c > 65536)
                    c = 65536;
                if (c < -65536)
                    c = -65536;
            end
            o[k] = c;
        end
        return o;
    endfunction

    function automatic bit ray_meets(vec3_t o, vec3_t d, int s, output longint t0,
                                     output longint t1);
        vec3_t l;
        longint tca, d2, r2;
        longint unsigned thc;
        for (int k = 0; k < 3; k++)
            l[k] = sat_q16(cen_m[s][k] - o[k]);
        tca = sat_q16(dot_q16(l, d));
        t0 = 0;
        t1 = 0;
        if (tca < 0)
            return 1'b0;
        d2 = dot_q16(l, l) - ((tca * tca) >>> 16);
        r2 = (rad_m[s] * rad_m[s]) >>> 16;
        if (d2 > r2)
            return 1'b0;
        thc = root_floor(longint'(r2 - d2) << 16);
        t0 = tca - longint'(thc);
        t1 = tca + longint'(thc);
        return 1'b1;
    endfunction

    function automatic shade_t shade_ray(vec3_t d);
        shade_t res;
        vec3_t o, ph, nv, nh, so, lv, ld;
        longint n, tnear, t0, t1, ndl;
        longint acc[3];
        int best;
        bit found, blocked;
        n = (count_m > NSPH) ? NSPH : count_m;
        o = org_m;
        found = 0;
        best = 0;
        tnear = 0;
        for (int i = 0; i < n; i++)
            if (ray_meets(o, d, i, t0, t1))
            begin
                if (t0 < 0)
                    t0 = t1;
                if (!found || t0 < tnear)
                begin
                    tnear = t0;
                    best = i;
                    found = 1;
                end
            end
        if (!found)
        begin
            res = '{BG_COLOR, BG_COLOR, BG_COLOR, 1'b0};
            return res;
        end
        tnear = sat_q16(tnear);
        for (int k = 0; k < 3; k++)
            ph[k] = sat_q16(o[k] + ((d[k] * tnear) >>> 16));
        for (int k = 0; k < 3; k++)
            nv[k] = sat_q16(ph[k] - cen_m[best][k]);
        nh = normalize_q16(nv);
        for (int k = 0; k < 3; k++)
        begin
            so[k] = sat_q16(ph[k] + nh[k]);
            acc[k] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (emit_m[i][0] == 0)
                continue;
            for (int k = 0; k < 3; k++)
                lv[k] = sat_q16(cen_m[i][k] - ph[k]);
            ld = normalize_q16(lv);
            blocked = 0;
            for (int j = 0; j < n && !blocked; j++)
                if (j != i && ray_meets(so, ld, j, t0, t1))
                    blocked = 1;
            if (blocked)
                continue;
            ndl = dot_q16(nh, ld);
            if (ndl < 0)
                ndl = 0;
            for (int k = 0; k < 3; k++)
                acc[k] += (((surf_m[best][k] * ndl) >> 16) * emit_m[i][k]) >> 12;
        end
        for (int k = 0; k < 3; k++)
            acc[k] += emit_m[best][k];
        res.r = (acc[0] > 65535) ? 16'hFFFF : acc[0][15:0];
        res.g = (acc[1] > 65535) ? 16'hFFFF : acc[1][15:0];
        res.b = (acc[2] > 65535) ? 16'hFFFF : acc[2][15:0];
        res.hit = 1'b1;
        return res;
    endfunction

    // one command transfer; start stays high on return
    task automatic send_cmd(logic op, logic [2:0] idx, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [30:0] rad, logic [15:0] sr,
                            logic [15:0] sg, logic [15:0] sb, logic [15:0] er,
                            logic [15:0] eg, logic [15:0] eb);
        vec3_t d;
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        start = 1'b1;
        operation = op;
        entry_index = idx;
        vec_x = x;
        vec_y = y;
        vec_z = z;
        radius = rad;
        surface_r = sr;
        surface_g = sg;
        surface_b = sb;
        emit_r = er;
        emit_g = eg;
        emit_b = eb;
        do
            @(posedge clk);
        while (busy);
        if (op == OPER_LOAD)
        begin
            cen_m[idx] = '{longint'(signed'(x)), longint'(signed'(y)), longint'(signed'(z))};
            rad_m[idx] = longint'(rad);
            surf_m[idx] = '{longint'(sr), longint'(sg), longint'(sb)};
            emit_m[idx] = '{longint'(er), longint'(eg), longint'(eb)};
            n_loads++;
        end
        else
        begin
            d = '{longint'(signed'(x)), longint'(signed'(y)), longint'(signed'(z))};
            shade_q = {shade_q, shade_ray(d)};
            n_traces++;
        end
    endtask

    task automatic load_sphere(int idx, int cx, int cy, int cz, int rad, int sr, int sg,
                               int sb, int er, int eg, int eb);
        send_cmd(OPER_LOAD, 3'(idx), cx, cy, cz, 31'(rad), 16'(sr), 16'(sg), 16'(sb),
                 16'(er), 16'(eg), 16'(eb));
    endtask

    task automatic trace(int x, int y, int z);
        send_cmd(OPER_TRACE, 3'($urandom), x, y, z, 31'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_X: org_m[0] = longint'(signed'(val));
            CFG_ORIGIN_Y: org_m[1] = longint'(signed'(val));
            CFG_ORIGIN_Z: org_m[2] = longint'(signed'(val));
            CFG_COUNT:    count_m = longint'(val[3:0]);
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_origin(int x, int y, int z);
        write_reg(CFG_ORIGIN_X, x);
        write_reg(CFG_ORIGIN_Y, y);
        write_reg(CFG_ORIGIN_Z, z);
    endtask

    function automatic int rand_q16(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // unit direction toward a loaded centre with some jitter, or a random one
    task automatic aimed_trace;
        real v[3], len;
        int s;
        s = $urandom_range(NSPH - 1);
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(3) == 0)
                v[k] = $itor(rand_q16(65536));
            else
                v[k] = $itor(cen_m[s][k] - org_m[k]) + $itor(rand_q16(40000));
        end
        len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (len < 1.0)
            len = 1.0;
        trace($rtoi(v[0] / len * 65536.0), $rtoi(v[1] / len * 65536.0),
              $rtoi(v[2] / len * 65536.0));
    endtask

    task automatic random_load(int idx);
        bit lit;
        lit = ($urandom_range(2) == 0);
        if ($urandom_range(9) == 0)
            send_cmd(OPER_LOAD, 3'(idx), $urandom, $urandom, $urandom, 31'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        else
            load_sphere(idx, rand_q16(655360), rand_q16(655360), rand_q16(655360),
                        $urandom_range(196608, 8192), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535),
                        lit ? $urandom_range(16384, 1) : 0, $urandom_range(16384),
                        $urandom_range(16384));
    endtask

    task automatic test_empty_scene;
        trace(65536, 0, 0);
        trace(32'h80000000, 32'h7FFFFFFF, 0);
    endtask

    task automatic test_directed;
        // two lights (three once sphere 6 is in use), one shadow caster, a twin of sphere 0 at equal distance
        load_sphere(0, 0, 0, 327680, 65536, 4096, 8192, 65535, 0, 0, 0);
        load_sphere(1, 0, 0, 327680, 65536, 65535, 65535, 65535, 0, 0, 0);
        load_sphere(2, 327680, 0, 327680, 32768, 0, 0, 0, 8192, 4096, 65535);
        load_sphere(3, 0, 393216, 327680, 32768, 0, 0, 0, 65535, 65535, 65535);
        load_sphere(4, 0, 196608, 327680, 16384, 4096, 4096, 4096, 0, 4096, 4096);
        load_sphere(5, 0, 0, 0, 131072, 4096, 4096, 4096, 0, 0, 0);
        load_sphere(6, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
                    65535, 65535, 65535, 65535, 65535, 65535);
        load_sphere(7, -655360, 0, 0, 65536, 65535, 0, 65535, 0, 0, 0);
        write_reg(CFG_COUNT, 5);
        trace(0, 0, 65536);
        trace(0, 0, -65536);
        trace(0, 0, 0);
        trace(46341, 0, 46341);
        trace(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        write_reg(CFG_COUNT, 6);
        trace(0, 0, 65536);
        trace(-65536, 0, 0);
        write_reg(CFG_COUNT, NSPH);
        trace(0, 0, 65536);
        trace(32'h80000000, 32'h80000000, 32'h80000000);
        write_reg(CFG_COUNT, 15);
        trace(-65536, 0, 0);
        trace(0, 65536, 0);
        set_origin(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        trace(65536, -65536, 65536);
        trace(-65536, 65536, -65536);
        set_origin(0, 0, 0);
        write_reg(CFG_COUNT, 0);
        trace(0, 0, 65536);
    endtask

    task automatic test_random(int pct, int items);
        int done;
        idle_pct = pct;
        done = 0;
        while (done < items)
        begin
            if ($urandom_range(7) == 0)
                set_origin($urandom, $urandom, $urandom);
            else
                set_origin(rand_q16(262144), rand_q16(262144), rand_q16(262144));
            write_reg(CFG_COUNT, ($urandom_range(9) == 0) ? $urandom_range(15)
                                                          : $urandom_range(5));
            for (int i = 0; i < 40; i++)
            begin
                if ($urandom_range(4) == 0)
                    random_load($urandom_range(NSPH - 1));
                else if ($urandom_range(9) == 0)
                    trace($urandom, $urandom, $urandom);
                else
                    aimed_trace();
                done++;
            end
        end
    endtask

    initial
    begin
        org_m = '{0, 0, 0};
        count_m = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_scene();
        test_directed();
        test_random(16, 430);
        test_random(70, 430);
        test_random(0, 430);
        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d loads, %0d traces (%0d hits), %0d register writes.",
                 n_loads, n_traces, n_hits, n_cfg);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/rssh_pkg.sv
hdl/rssh_ram.sv
hdl/rssh_ctrl.sv
hdl/rssh_dp.sv
hdl/ray_sphere_nearest_hit_shader_top.sv
verif/ray_sphere_nearest_hit_shader_top_tb.sv
